[hw/rtl/eavr_pkg.sv]
// Shared types, widths and constants for the Euler Z-X-Z vector rotation core.
// Used by the angle front end, the CORDIC pipeline, the matrix datapath and the top level.
// No dependencies.
package eavr_pkg;

	localparam int VEC_W = 32;
	localparam int ANG_W = 26;
	localparam int Q_BITS = 30;
	localparam int TRIG_W = 32;
	localparam int CORDIC_W = 34;
	localparam int Z_W = 33;
	localparam int MAX_TRIG = 24;

	localparam int FRAC_BITS_DEF = 16;
	localparam int TRIG_STAGES_DEF = 16;

	// pi/180 in Q0.32
	localparam logic signed [27:0] DEG2RAD_Q32 = 28'sd74961321;
	// 1/K in Q2.30
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
	// ceil(2^32 / 360), exact quotient for operands below 2^20
	localparam logic [23:0] RECIP_360 = 24'd11930465;

	localparam logic signed [Z_W-1:0] ATAN_TAB [MAX_TRIG] = '{
		33'sh03243F6A8, 33'sh01DAC6705, 33'sh00FADBAFC, 33'sh007F56EA6,
		33'sh003FEAB76, 33'sh001FFD55B, 33'sh000FFFAAA, 33'sh0007FFF55,
		33'sh0003FFFEA, 33'sh0001FFFFD, 33'sh0000FFFFF, 33'sh00007FFFF,
		33'sh00003FFFF, 33'sh00001FFFF, 33'sh00000FFFF, 33'sh000007FFF,
		33'sh000003FFF, 33'sh000001FFF, 33'sh000000FFF, 33'sh0000007FF,
		33'sh0000003FF, 33'sh0000001FF, 33'sh0000000FF, 33'sh00000007F
	};

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_t;

endpackage

[hw/rtl/eavr_angle_prep.sv]
// Angle front end: wraps a Q.FRAC_BITS degree angle into +/-90 degrees, converts to Q2.30 radians.
// Three register stages. Depends on eavr_pkg.
module eavr_angle_prep
	import eavr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [ANG_W-1:0] angle,
	output logic signed [TRIG_W-1:0] z,
	output logic                    neg
);

	localparam int HW = ANG_W - FRAC_BITS;
	localparam int UW = HW + 10;
	localparam int QW = UW - 8;
	localparam int OFS_K = ((1 << (HW - 1)) + 359) / 360;
	localparam int OFS = 360 * OFS_K;
	localparam int AW = FRAC_BITS + 10;
	localparam int PW = AW + 28;

	localparam logic signed [AW-1:0] DEG_FULL = AW'(64'(360) << FRAC_BITS);
	localparam logic signed [AW-1:0] DEG_HALF = AW'(64'(180) << FRAC_BITS);
	localparam logic signed [AW-1:0] DEG_QUARTER = AW'(64'(90) << FRAC_BITS);
	localparam logic signed [PW-1:0] RAD_HALF = PW'(1) <<< (FRAC_BITS + 1);

	logic [UW-1:0]          u;
	logic [UW+23:0]         q_prod;
	logic [UW-1:0]          u_s1;
	logic [QW-1:0]          q_s1;
	logic [FRAC_BITS-1:0]   lo_s1;
	logic [UW-1:0]          r_full;
	logic signed [AW-1:0]   a_mod;
	logic signed [AW-1:0]   a_fold;
	logic                   neg_fold;
	logic signed [AW-1:0]   a_s2;
	logic                   neg_s2;
	logic signed [PW-1:0]   rad_prod;
	logic signed [PW-1:0]   rad_sh;
	logic signed [TRIG_W-1:0] z_s3;
	logic                   neg_s3;

	// floor(angle / 2^F) biased by a multiple of 360 so it stays nonnegative
	assign u = UW'(int'(signed'(angle[ANG_W-1:FRAC_BITS])) + OFS);
	assign q_prod = (UW + 24)'(u) * (UW + 24)'(RECIP_360);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1  <= u;
			q_s1  <= q_prod[UW+23:32];
			lo_s1 <= angle[FRAC_BITS-1:0];
		end
	end

	assign r_full = u_s1 - UW'(q_s1) * UW'(10'd360);
	assign a_mod = signed'({1'b0, r_full[8:0], lo_s1});

	always_comb begin
		logic signed [AW-1:0] a_w;
		a_w = (a_mod >= DEG_HALF) ? a_mod - DEG_FULL : a_mod;
		a_fold = a_w;
		neg_fold = 1'b0;
		if (a_w > DEG_QUARTER) begin
			a_fold = a_w - DEG_HALF;
			neg_fold = 1'b1;
		end else if (a_w < -DEG_QUARTER) begin
			a_fold = a_w + DEG_HALF;
			neg_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= a_fold;
			neg_s2 <= neg_fold;
		end
	end

	assign rad_prod = PW'(a_s2) * PW'(DEG2RAD_Q32);
	assign rad_sh = (rad_prod + RAD_HALF) >>> (FRAC_BITS + 2);

	always_ff @(posedge clk) begin
		if (en) begin
			z_s3   <= rad_sh[TRIG_W-1:0];
			neg_s3 <= neg_s2;
		end
	end

	assign z = z_s3;
	assign neg = neg_s3;

endmodule

[hw/rtl/eavr_cordic.sv]
// Unrolled rotation-mode CORDIC: one register stage per iteration, then a sign-fix stage.
// Produces cosine and sine in Q2.30. Depends on eavr_pkg.
module eavr_cordic
	import eavr_pkg::*;
#(
	parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [TRIG_W-1:0] z,
	input  logic                     neg,
	output trig_t                    tr
);

	logic signed [CORDIC_W-1:0] x_s [TRIG_STAGES];
	logic signed [CORDIC_W-1:0] y_s [TRIG_STAGES];
	logic signed [Z_W-1:0]      z_s [TRIG_STAGES];
	logic                       n_s [TRIG_STAGES];
	trig_t                      tr_s;

	for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_iter
		logic signed [CORDIC_W-1:0] xi;
		logic signed [CORDIC_W-1:0] yi;
		logic signed [Z_W-1:0]      zi;
		logic                       ni;

		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = Z_W'(z);
			assign ni = neg;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ni = n_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - ATAN_TAB[i];
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + ATAN_TAB[i];
				end
				n_s[i] <= ni;
			end
		end
	end

	// undo the half-turn fold
	always_ff @(posedge clk) begin
		if (en) begin
			tr_s.cos_v <= n_s[TRIG_STAGES-1] ? TRIG_W'(-x_s[TRIG_STAGES-1])
			                                 : TRIG_W'(x_s[TRIG_STAGES-1]);
			tr_s.sin_v <= n_s[TRIG_STAGES-1] ? TRIG_W'(-y_s[TRIG_STAGES-1])
			                                 : TRIG_W'(y_s[TRIG_STAGES-1]);
		end
	end

	assign tr = tr_s;

endmodule

[hw/rtl/eavr_matrix.sv]
// Z-X-Z rotation matrix build and apply: coefficient products, triple products,
// matrix-vector products, then sum, round and saturate. Four stages. Depends on eavr_pkg.
module eavr_matrix
	import eavr_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  trig_t                    t1,
	input  trig_t                    t2,
	input  trig_t                    t3,
	input  logic signed [VEC_W-1:0]  vx,
	input  logic signed [VEC_W-1:0]  vy,
	input  logic signed [VEC_W-1:0]  vz,
	output logic signed [VEC_W-1:0]  rot_x,
	output logic signed [VEC_W-1:0]  rot_y,
	output logic signed [VEC_W-1:0]  rot_z,
	output logic                     saturated
);

	localparam int MW = TRIG_W + 1;
	localparam int PW = MW + VEC_W;
	localparam int SW = PW + 2;
	localparam int RW = SW - Q_BITS;
	localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (Q_BITS - 1);
	localparam logic signed [RW-1:0] OUT_MAX = RW'(64'sd2147483647);
	localparam logic signed [RW-1:0] OUT_MIN = RW'(-64'sd2147483648);

	function automatic logic signed [TRIG_W-1:0] qmul(
		input logic signed [TRIG_W-1:0] a,
		input logic signed [TRIG_W-1:0] b
	);
		logic signed [2*TRIG_W-1:0] p;
		p = (2 * TRIG_W)'(a) * (2 * TRIG_W)'(b);
		p = p + ((2 * TRIG_W)'(1) <<< (Q_BITS - 1));
		p = p >>> Q_BITS;
		return p[TRIG_W-1:0];
	endfunction

	logic signed [TRIG_W-1:0] c1c3_s1, s1c2_s1, c1s3_s1, s1c3_s1, s1s3_s1;
	logic signed [TRIG_W-1:0] c1c2_s1, s1s2_s1, c1s2_s1, s2s3_s1, s2c3_s1;
	logic signed [TRIG_W-1:0] c2_s1, c3_s1, s3_s1;
	logic signed [VEC_W-1:0]  v_s1 [3];
	logic signed [MW-1:0]     m_s2 [9];
	logic signed [VEC_W-1:0]  v_s2 [3];
	logic signed [PW-1:0]     pr_s3 [9];
	logic signed [VEC_W-1:0]  rot_s4 [3];
	logic                     sat_s4;
	logic signed [VEC_W-1:0]  rot_c [3];
	logic                     sat_c [3];

	always_ff @(posedge clk) begin
		if (en) begin
			c1c3_s1 <= qmul(t1.cos_v, t3.cos_v);
			s1c2_s1 <= qmul(t1.sin_v, t2.cos_v);
			c1s3_s1 <= qmul(t1.cos_v, t3.sin_v);
			s1c3_s1 <= qmul(t1.sin_v, t3.cos_v);
			s1s3_s1 <= qmul(t1.sin_v, t3.sin_v);
			c1c2_s1 <= qmul(t1.cos_v, t2.cos_v);
			s1s2_s1 <= qmul(t1.sin_v, t2.sin_v);
			c1s2_s1 <= qmul(t1.cos_v, t2.sin_v);
			s2s3_s1 <= qmul(t2.sin_v, t3.sin_v);
			s2c3_s1 <= qmul(t2.sin_v, t3.cos_v);
			c2_s1   <= t2.cos_v;
			c3_s1   <= t3.cos_v;
			s3_s1   <= t3.sin_v;
			v_s1[0] <= vx;
			v_s1[1] <= vy;
			v_s1[2] <= vz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2[0] <= MW'(c1c3_s1) - MW'(qmul(s1c2_s1, s3_s1));
			m_s2[1] <= MW'(c1s3_s1) + MW'(qmul(s1c2_s1, c3_s1));
			m_s2[2] <= MW'(s1s2_s1);
			m_s2[3] <= -MW'(s1c3_s1) - MW'(qmul(c1c2_s1, s3_s1));
			m_s2[4] <= -MW'(s1s3_s1) + MW'(qmul(c1c2_s1, c3_s1));
			m_s2[5] <= MW'(c1s2_s1);
			m_s2[6] <= MW'(s2s3_s1);
			m_s2[7] <= -MW'(s2c3_s1);
			m_s2[8] <= MW'(c2_s1);
			v_s2    <= v_s1;
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_prod
		always_ff @(posedge clk) begin
			if (en) begin
				pr_s3[k] <= PW'(m_s2[k]) * PW'(v_s2[k % 3]);
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_row
		logic signed [SW-1:0] acc;
		logic signed [SW-1:0] acc_r;
		logic signed [RW-1:0] res;

		assign acc = SW'(pr_s3[3*k]) + SW'(pr_s3[3*k+1]) + SW'(pr_s3[3*k+2]);
		assign acc_r = (acc + ROUND_HALF) >>> Q_BITS;
		assign res = acc_r[RW-1:0];

		always_comb begin
			rot_c[k] = res[VEC_W-1:0];
			sat_c[k] = 1'b0;
			if (res > OUT_MAX) begin
				rot_c[k] = OUT_MAX[VEC_W-1:0];
				sat_c[k] = 1'b1;
			end else if (res < OUT_MIN) begin
				rot_c[k] = OUT_MIN[VEC_W-1:0];
				sat_c[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s4 <= rot_c;
			sat_s4 <= sat_c[0] | sat_c[1] | sat_c[2];
		end
	end

	assign rot_x = rot_s4[0];
	assign rot_y = rot_s4[1];
	assign rot_z = rot_s4[2];
	assign saturated = sat_s4;

endmodule

[hw/rtl/euler_angle_vector_rotation_core.sv]
// Top level of the Euler Z-X-Z vector rotation core: three angle front ends, three CORDICs,
// the matrix datapath, and the valid/vector delay lines. Depends on eavr_pkg and all eavr_ modules.
//
//   channel | signals                                            | dir
//   input   | in_valid, in_ready, vec_x/y/z, first/second/third_angle | in
//   output  | out_valid, out_ready, rot_x/y/z, saturated          | out
//
// One transaction per cycle sustained while out_ready is held high; the pipe is 3 angle stages,
// TRIG_STAGES CORDIC iterations plus a sign stage, and 4 matrix stages.
// Reset clears the valid line only; the datapath holds no state between transactions.
// When the last stage holds a result that is not taken, the whole pipe holds and in_ready drops.
module euler_angle_vector_rotation_core
	import eavr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VEC_W-1:0] vec_x,
	input  logic signed [VEC_W-1:0] vec_y,
	input  logic signed [VEC_W-1:0] vec_z,
	input  logic signed [ANG_W-1:0] first_angle,
	input  logic signed [ANG_W-1:0] second_angle,
	input  logic signed [ANG_W-1:0] third_angle,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VEC_W-1:0] rot_x,
	output logic signed [VEC_W-1:0] rot_y,
	output logic signed [VEC_W-1:0] rot_z,
	output logic                    saturated
);

	localparam int PRE_LAT = 3;
	localparam int COR_LAT = TRIG_STAGES + 1;
	localparam int MAT_LAT = 4;
	localparam int VEC_DLY = PRE_LAT + COR_LAT;
	localparam int LAT = VEC_DLY + MAT_LAT;

	logic                    en;
	logic                    vld_q [LAT];
	logic signed [VEC_W-1:0] vx_q [VEC_DLY];
	logic signed [VEC_W-1:0] vy_q [VEC_DLY];
	logic signed [VEC_W-1:0] vz_q [VEC_DLY];
	logic signed [TRIG_W-1:0] z1, z2, z3;
	logic                    n1, n2, n3;
	trig_t                   t1, t2, t3;

	// advance unless a finished result is stuck at the output
	assign en = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_q[0] <= vec_x;
			vy_q[0] <= vec_y;
			vz_q[0] <= vec_z;
			for (int i = 1; i < VEC_DLY; i++) begin
				vx_q[i] <= vx_q[i-1];
				vy_q[i] <= vy_q[i-1];
				vz_q[i] <= vz_q[i-1];
			end
		end
	end

	eavr_angle_prep #(.FRAC_BITS(FRAC_BITS)) u_prep1 (
		.clk(clk), .en(en), .angle(first_angle), .z(z1), .neg(n1)
	);
	eavr_angle_prep #(.FRAC_BITS(FRAC_BITS)) u_prep2 (
		.clk(clk), .en(en), .angle(second_angle), .z(z2), .neg(n2)
	);
	eavr_angle_prep #(.FRAC_BITS(FRAC_BITS)) u_prep3 (
		.clk(clk), .en(en), .angle(third_angle), .z(z3), .neg(n3)
	);

	eavr_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic1 (
		.clk(clk), .en(en), .z(z1), .neg(n1), .tr(t1)
	);
	eavr_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic2 (
		.clk(clk), .en(en), .z(z2), .neg(n2), .tr(t2)
	);
	eavr_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic3 (
		.clk(clk), .en(en), .z(z3), .neg(n3), .tr(t3)
	);

	eavr_matrix u_matrix (
		.clk(clk),
		.en(en),
		.t1(t1),
		.t2(t2),
		.t3(t3),
		.vx(vx_q[VEC_DLY-1]),
		.vy(vy_q[VEC_DLY-1]),
		.vz(vz_q[VEC_DLY-1]),
		.rot_x(rot_x),
		.rot_y(rot_y),
		.rot_z(rot_z),
		.saturated(saturated)
	);

`ifndef SYNTHESIS
	localparam logic signed [VEC_W-1:0] OUT_MAX = 32'sh7FFFFFFF;
	localparam logic signed [VEC_W-1:0] OUT_MIN = 32'sh80000000;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (rot_x == OUT_MAX || rot_x == OUT_MIN ||
			rot_y == OUT_MAX || rot_y == OUT_MIN || rot_z == OUT_MAX || rot_z == OUT_MIN))
		else $error("saturated flag without a clipped component");

	a_idle_output_follows: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipe held with empty output stage");
`endif

endmodule

[sim/euler_angle_vector_rotation_core_test.sv]
// Self-checking testbench for euler_angle_vector_rotation_core: Z-X-Z Euler rotation of Q16.16
// vectors, checked against a fixed-point predictor kept here. Depends on eavr_pkg and the core.
module euler_angle_vector_rotation_core_test
	import eavr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int STAGES = TRIG_STAGES_DEF;
	localparam longint DEG360 = longint'(360) << FRAC;
	localparam longint DEG180 = longint'(180) << FRAC;
	localparam longint DEG90 = longint'(90) << FRAC;
	localparam int ANG_LIM = 360 << FRAC;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct {
		logic signed [VEC_W-1:0] x, y, z;
		logic signed [ANG_W-1:0] a1, a2, a3;
	} rotation_req_t;

	typedef struct {
		logic signed [VEC_W-1:0] x, y, z;
		logic sat;
	} rotated_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [VEC_W-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic signed [ANG_W-1:0] first_angle = '0, second_angle = '0, third_angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [VEC_W-1:0] rot_x, rot_y, rot_z;
	logic saturated;

	rotated_vec_t rotation_q[$];
	int accepted_cnt = 0;
	int result_cnt = 0;
	int sat_cnt = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	bit send_idles = 1'b1;
	bit recv_stalls = 1'b1;
	int hold_off_cycles = 0;

	euler_angle_vector_rotation_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.first_angle(first_angle), .second_angle(second_angle), .third_angle(third_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .saturated(saturated)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint round_q(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return round_q(a * b, Q_BITS);
	endfunction

	// Quadrant-reduce, convert to radians, run the shift-add sin/cos iterations
	function automatic void angle_trig(input longint ang, output longint c, output longint s);
		longint a, x, y, z, nx;
		bit flip;
		a = ang % DEG360;
		if (a < 0) a += DEG360;
		if (a >= DEG180) a -= DEG360;
		flip = 1'b0;
		if (a > DEG90) begin
			a -= DEG180;
			flip = 1'b1;
		end else if (a < -DEG90) begin
			a += DEG180;
			flip = 1'b1;
		end
		z = round_q(a * longint'(DEG2RAD_Q32), FRAC + 2);
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic rotated_vec_t rotate_vector(rotation_req_t r);
		longint c1, s1, c2, s2, c3, s3, acc, v;
		longint m[3][3];
		longint vin[3];
		longint res[3];
		rotated_vec_t o;
		angle_trig(longint'(r.a1), c1, s1);
		angle_trig(longint'(r.a2), c2, s2);
		angle_trig(longint'(r.a3), c3, s3);
		m[0][0] = qmul(c1, c3) - qmul(qmul(s1, c2), s3);
		m[0][1] = qmul(c1, s3) + qmul(qmul(s1, c2), c3);
		m[0][2] = qmul(s1, s2);
		m[1][0] = -qmul(s1, c3) - qmul(qmul(c1, c2), s3);
		m[1][1] = -qmul(s1, s3) + qmul(qmul(c1, c2), c3);
		m[1][2] = qmul(c1, s2);
		m[2][0] = qmul(s2, s3);
		m[2][1] = -qmul(s2, c3);
		m[2][2] = c2;
		vin[0] = longint'(r.x);
		vin[1] = longint'(r.y);
		vin[2] = longint'(r.z);
		o.sat = 1'b0;
		for (int k = 0; k < 3; k++) begin
			acc = m[k][0] * vin[0] + m[k][1] * vin[1] + m[k][2] * vin[2];
			v = round_q(acc, Q_BITS);
			if (v > 64'sd2147483647) begin
				v = 64'sd2147483647;
				o.sat = 1'b1;
			end else if (v < -64'sd2147483648) begin
				v = -64'sd2147483648;
				o.sat = 1'b1;
			end
			res[k] = v;
		end
		o.x = res[0][31:0];
		o.y = res[1][31:0];
		o.z = res[2][31:0];
		return o;
	endfunction

	// Predict on every input transaction; values are read before this edge's updates land
	always @(posedge clk) begin
		rotation_req_t r;
		if (in_valid && in_ready) begin
			r.x = vec_x; r.y = vec_y; r.z = vec_z;
			r.a1 = first_angle; r.a2 = second_angle; r.a3 = third_angle;
			rotation_q.push_back(rotate_vector(r));
			accepted_cnt++;
		end
	end

	always @(posedge clk) begin
		rotated_vec_t e;
		if (out_valid && out_ready) begin
			result_cnt++;
			if (saturated) sat_cnt++;
			if (rotation_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result x=%0d y=%0d z=%0d sat=%0b",
						rot_x, rot_y, rot_z, saturated);
			end else begin
				e = rotation_q.pop_front();
				if (rot_x !== e.x || rot_y !== e.y || rot_z !== e.z || saturated !== e.sat) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch #%0d: exp x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
							result_cnt, e.x, e.y, e.z, e.sat, rot_x, rot_y, rot_z, saturated);
				end
			end
		end
	end

	// Receiver: random stall bursts, or one long hold-off when requested
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_ready = 1'b0;
			hold_off_cycles--;
		end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
			out_ready = 1'b0;
			repeat ($urandom_range(1, 4)) begin
				@(negedge clk);
				if (hold_off_cycles > 0) hold_off_cycles--;
			end
			out_ready = 1'b1;
		end else begin
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("FAILURE");
			$finish;
		end
	end

	// Present one transaction from a falling edge and hold it until it is taken
	task automatic send_rotation(rotation_req_t r);
		int target;
		if (send_idles && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		vec_x = r.x; vec_y = r.y; vec_z = r.z;
		first_angle = r.a1; second_angle = r.a2; third_angle = r.a3;
		in_valid = 1'b1;
		target = accepted_cnt + 1;
		wait (accepted_cnt >= target);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid = 1'b0;
		while (rotation_q.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	function automatic rotation_req_t make_req(int x, int y, int z, int a1, int a2, int a3);
		rotation_req_t r;
		r.x = x; r.y = y; r.z = z;
		r.a1 = a1[ANG_W-1:0]; r.a2 = a2[ANG_W-1:0]; r.a3 = a3[ANG_W-1:0];
		return r;
	endfunction

	function automatic int rand_angle();
		case ($urandom_range(0, 9))
			0: return $signed($urandom) >>> (32 - ANG_W);   // whole field, wraps past 360
			1: return $urandom_range(0, 8) * (45 << FRAC) - ANG_LIM;
			default: return int'($urandom_range(0, 2 * ANG_LIM)) - ANG_LIM;
		endcase
	endfunction

	function automatic int rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			1: return $signed($urandom) >>> $urandom_range(8, 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic rotation_req_t rand_req();
		return make_req(rand_comp(), rand_comp(), rand_comp(),
			rand_angle(), rand_angle(), rand_angle());
	endfunction

	task automatic test_directed();
		int one = 1 << 16;
		int mx = 32'sh7FFFFFFF;
		int mn = 32'sh80000000;
		int d = 1 << FRAC;
		int amax = (1 << (ANG_W - 1)) - 1;
		int amin = -(1 << (ANG_W - 1));
		send_rotation(make_req(one, 2 * one, 3 * one, 0, 0, 0));
		send_rotation(make_req(mx, mn, mx, 0, 0, 0));
		send_rotation(make_req(mn, mx, mn, 0, 0, 0));
		send_rotation(make_req(one, 0, 0, 90 * d, 0, 0));
		send_rotation(make_req(0, one, 0, 0, 90 * d, 0));
		send_rotation(make_req(0, 0, one, 0, 0, 90 * d));
		send_rotation(make_req(one, one, one, -90 * d, -90 * d, -90 * d));
		send_rotation(make_req(one, -one, one, 180 * d, -180 * d, 180 * d));
		send_rotation(make_req(one, one, -one, 360 * d, -360 * d, 360 * d));
		send_rotation(make_req(one, one, one, 91 * d, -91 * d, 179 * d));
		send_rotation(make_req(one, one, one, 90 * d + 1, -90 * d - 1, 270 * d));
		send_rotation(make_req(one, 2 * one, -one, amax, amin, amax));
		send_rotation(make_req(-one, one, 7 * one, 400 * d, -500 * d, 720 * d - 1));
		send_rotation(make_req(mx, mx, mx, 45 * d, 45 * d, 45 * d));
		send_rotation(make_req(mn, mn, mn, -45 * d, 135 * d, 30 * d));
		send_rotation(make_req(mx, mn, mx, 60 * d, 30 * d, -120 * d));
		send_rotation(make_req(-1, 1, 0, 1, -1, 1));
		send_rotation(make_req(32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F,
			26'h1555555, 26'h2AAAAAA, 26'h0F0F0F0));
		drain_results();
	endtask

	task automatic test_random_traffic(int n);
		repeat (n) send_rotation(rand_req());
		drain_results();
	endtask

	// Receiver stops for a long stretch while items keep coming, so the pipe fills
	task automatic test_backpressure();
		hold_off_cycles = 120;
		repeat (60) send_rotation(rand_req());
		drain_results();
	endtask

	task automatic test_full_rate();
		send_idles = 1'b0;
		recv_stalls = 1'b0;
		repeat (200) send_rotation(rand_req());
		drain_results();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_traffic(300);
		test_backpressure();
		test_random_traffic(300);
		test_full_rate();
		repeat (40) @(posedge clk);
		$display("%0d rotations checked (%0d saturated), angles across and past +/-360 deg,",
			result_cnt, sat_cnt);
		$display("with random idles, a long output stall and a full-rate stretch; %0d mismatches",
			mismatch_cnt);
		if (mismatch_cnt == 0 && rotation_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[euler_angle_vector_rotation_core.f]
hw/rtl/eavr_pkg.sv
hw/rtl/eavr_angle_prep.sv
hw/rtl/eavr_cordic.sv
hw/rtl/eavr_matrix.sv
hw/rtl/euler_angle_vector_rotation_core.sv
sim/euler_angle_vector_rotation_core_test.sv
